// ===== sv/olis_pkg.sv =====
package olis_pkg;

  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SHFT,
    ST_PUT,
    ST_RESP
  } olis_state_e;

  typedef struct packed {
    logic             inserted;
    logic             found;
    logic [IDX_W-1:0] found_index;
  } olis_res_t;

endpackage

// ===== sv/olis_if.sv =====
interface olis_in_if import olis_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output position, output value, input ready);
  modport sink   (input valid, input position, input value, output ready);
endinterface

interface olis_out_if import olis_pkg::*;;
  logic             valid;
  logic             ready;
  logic             inserted;
  logic             found;
  logic [IDX_W-1:0] found_index;

  modport source (output valid, output inserted, output found, output found_index, input ready);
  modport sink   (input valid, input inserted, input found, input found_index, output ready);
endinterface

// ===== sv/olis_mem.sv =====
module olis_mem import olis_pkg::*; #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     wa_i,
  input  logic [DATA_W-1:0] wd_i,
  input  logic              re_i,
  input  logic [AW-1:0]     ra_i,
  output logic [DATA_W-1:0] rd_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_q <= mem[ra_i];
    end
  end

  assign rd_o = rd_q;

endmodule

// ===== sv/olis_seq.sv =====
module olis_seq import olis_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned AW       = 6,
  parameter int unsigned LW       = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] value_i,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_wa_o,
  output logic [DATA_W-1:0] mem_wd_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_ra_o,
  input  logic [DATA_W-1:0] mem_rd_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output olis_res_t         res_o
);

  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;

  olis_state_e state_q, state_d;
  logic [LW-1:0]     len_q, len_d;
  logic [LW-1:0]     pos_q, pos_d;
  logic              ok_q, ok_d;
  logic              hit_q, hit_d;
  logic [AW-1:0]     where_q, where_d;
  logic [LW-1:0]     rd_cnt_q, rd_cnt_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]     cmp_addr_q, cmp_addr_d;
  logic              wv_q, wv_d;
  logic [AW-1:0]     wa_q, wa_d;
  logic [DATA_W-1:0] val_q;

  logic          accept;
  logic          match;
  logic          issue;
  logic          srch_done;
  logic [LW-1:0] limit;
  logic          fits;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign fits      = (CW'(position_i) <= CW'(len_q)) && (len_q < LW'(CAPACITY));
  assign limit     = ok_q ? pos_q : len_q;
  assign match     = cmp_vld_q && (mem_rd_i == val_q);
  assign srch_done = !cmp_vld_q && (hit_q || (rd_cnt_q >= limit));
  assign issue     = !hit_q && !match && (rd_cnt_q < limit);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SRCH;
      end
      ST_SRCH: begin
        if (srch_done) state_d = ok_q ? ST_SHFT : ST_RESP;
      end
      ST_SHFT: begin
        if ((rd_cnt_q == pos_q) && !wv_q) state_d = ST_PUT;
      end
      ST_PUT:  state_d = ST_RESP;
      ST_RESP: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    len_d      = len_q;
    pos_d      = pos_q;
    ok_d       = ok_q;
    hit_d      = hit_q;
    where_d    = where_q;
    rd_cnt_d   = rd_cnt_q;
    cmp_vld_d  = 1'b0;
    cmp_addr_d = cmp_addr_q;
    wv_d       = 1'b0;
    wa_d       = wa_q;
    mem_we_o   = 1'b0;
    mem_wa_o   = wa_q;
    mem_wd_o   = mem_rd_i;
    mem_re_o   = 1'b0;
    mem_ra_o   = AW'(rd_cnt_q);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d    = LW'(position_i);
          ok_d     = fits;
          hit_d    = 1'b0;
          where_d  = '0;
          rd_cnt_d = '0;
        end
      end
      ST_SRCH: begin
        // scan entries ahead of the insert point, all if rejected; none move
        mem_re_o   = issue;
        cmp_vld_d  = issue;
        cmp_addr_d = AW'(rd_cnt_q);
        if (issue) rd_cnt_d = LW'(rd_cnt_q + 1'b1);
        if (match && !hit_q) begin
          hit_d   = 1'b1;
          where_d = cmp_addr_q;
        end
        if (srch_done) rd_cnt_d = len_q;
      end
      ST_SHFT: begin
        // read entry i-1 while writing entry i, read last cycle, to i+1
        if (rd_cnt_q != pos_q) begin
          mem_re_o = 1'b1;
          mem_ra_o = AW'(rd_cnt_q - 1'b1);
          rd_cnt_d = LW'(rd_cnt_q - 1'b1);
          wv_d     = 1'b1;
          wa_d     = AW'(rd_cnt_q);
        end
        mem_we_o = wv_q;
      end
      ST_PUT: begin
        mem_we_o = 1'b1;
        mem_wa_o = AW'(pos_q);
        mem_wd_o = val_q;
        len_d    = LW'(len_q + 1'b1);
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      len_q      <= '0;
      pos_q      <= '0;
      ok_q       <= 1'b0;
      hit_q      <= 1'b0;
      where_q    <= '0;
      rd_cnt_q   <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_addr_q <= '0;
      wv_q       <= 1'b0;
      wa_q       <= '0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      pos_q      <= pos_d;
      ok_q       <= ok_d;
      hit_q      <= hit_d;
      where_q    <= where_d;
      rd_cnt_q   <= rd_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_addr_q <= cmp_addr_d;
      wv_q       <= wv_d;
      wa_q       <= wa_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) val_q <= value_i;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);

  // an accepted insert is itself a match when nothing earlier matched
  always_comb begin
    res_o.inserted    = ok_q;
    res_o.found       = hit_q || ok_q;
    res_o.found_index = '0;
    if (hit_q) begin
      res_o.found_index = IDX_W'(where_q);
    end else if (ok_q) begin
      res_o.found_index = IDX_W'(pos_q);
    end
  end

endmodule

// ===== sv/ordered_list_insert_search_unit.sv =====
// Channel | Dir | Handshake     | Payload
// in_i    | in  | valid / ready | position[6:0], value[31:0] signed
// out_o   | out | valid / ready | inserted, found, found_index[5:0]
//
// Timing: the single read port sets the pace: the search reads up to pos
// entries (len for a rejected insert), stopping at the first match, and the
// shift moves len - pos entries, len being the list length before it.
// Reset: length and control clear at once; the entry memory is not cleared.
// Stalls: a result waits in the output register; the next transaction is
// taken while it waits, and the sequencer holds only if the register is full.
module ordered_list_insert_search_unit import olis_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  olis_in_if.sink     in_i,
  olis_out_if.source  out_o
);

  // address and length widths follow from the capacity
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = $clog2(CAPACITY + 1);

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;
  logic [DATA_W-1:0] mem_rd;

  logic      res_valid;
  logic      res_ready;
  olis_res_t res;

  // output register
  logic      out_vld_q, out_vld_d;
  olis_res_t out_res_q;

  olis_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i (clk_i),
    .we_i  (mem_we),
    .wa_i  (mem_wa),
    .wd_i  (mem_wd),
    .re_i  (mem_re),
    .ra_i  (mem_ra),
    .rd_o  (mem_rd)
  );

  olis_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .LW       (LW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .position_i  (in_i.position),
    .value_i     (in_i.value),
    .mem_we_o    (mem_we),
    .mem_wa_o    (mem_wa),
    .mem_wd_o    (mem_wd),
    .mem_re_o    (mem_re),
    .mem_ra_o    (mem_ra),
    .mem_rd_i    (mem_rd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // register is free when empty or draining this cycle
  assign res_ready = !out_vld_q || out_o.ready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_o.ready) out_vld_d = 1'b0;
    if (res_valid && res_ready) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_res_q <= res;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.inserted    = out_res_q.inserted;
  assign out_o.found       = out_res_q.found;
  assign out_o.found_index = out_res_q.found_index;

endmodule
